[rtl/dfd_pkg.sv]
// dfd_pkg: shared types and constants of the divide fault decode and fixup block
`timescale 1ns / 1ps

package dfd_pkg;

	// register file geometry
	localparam int unsigned NREGS  = 16;
	localparam int unsigned RIDX_W = $clog2(NREGS);

	// fixed register numbers
	localparam logic [RIDX_W-1:0] RAX_IDX = 4'd0;
	localparam logic [RIDX_W-1:0] RDX_IDX = 4'd2;

	// instruction byte codes
	localparam logic [7:0] PFX_OPSIZE = 8'h66;
	localparam logic [7:0] PFX_ADSIZE = 8'h67;
	localparam logic [7:0] OPC_DIV    = 8'hF7;
	localparam logic [3:0] REX_HI     = 4'h4;

	// decode status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PREFIX  = 2'd1;
	localparam logic [1:0] ST_OPCODE  = 2'd2;
	localparam logic [1:0] ST_REGFLD  = 2'd3;

	// input item
	typedef struct packed {
		logic        func;
		logic [3:0]  reg_index;
		logic [63:0] reg_value;
		logic [63:0] insn_bytes;
		logic [63:0] fault_rip;
		logic [63:0] mem_operand;
	} item_t;

	// result item
	typedef struct packed {
		logic [63:0] new_rax;
		logic [63:0] new_rdx;
		logic [63:0] next_rip;
		logic [3:0]  insn_length;
		logic [63:0] eff_addr;
		logic        uses_memory;
		logic [1:0]  status;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;   // take the input item
		logic wr_item;   // register write item
		logic rd_ops;    // read base and index registers
		logic addr;      // decode, address and divisor step, read rax
		logic fix;       // rax fixup and result load
		logic wr_rdx;    // rdx write back
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_write;
	} dp_stat_t;

endpackage

[rtl/dfd_ctrl.sv]
// dfd_ctrl: sequencing state machine of the divide fault decode and fixup block
`timescale 1ns / 1ps

module dfd_ctrl import dfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_ADDR = 5'b00100,
		S_FIX  = 5'b01000,
		S_WB   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_READ;
			S_READ: state_d = stat.is_write ? S_IDLE : S_ADDR;
			S_ADDR: state_d = S_FIX;
			S_FIX:  state_d = S_WB;
			S_WB:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd.capture = (state_q == S_IDLE) && start;
		cmd.wr_item = (state_q == S_READ) && stat.is_write;
		cmd.rd_ops  = (state_q == S_READ) && !stat.is_write;
		cmd.addr    = (state_q == S_ADDR);
		cmd.fix     = (state_q == S_FIX);
		cmd.wr_rdx  = (state_q == S_WB);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.wr_item || cmd.fix;
		end
	end

endmodule

[rtl/dfd_datapath.sv]
// dfd_datapath: register file, instruction decode, address and fixup datapath
`timescale 1ns / 1ps

module dfd_datapath import dfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	input  item_t      item,
	output dp_stat_t   stat,
	output result_t    result
);

	function automatic logic [7:0] byte_at(input logic [63:0] b, input logic [2:0] p);
		byte_at = b[{p, 3'b000} +: 8];
	endfunction

	// captured item
	item_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
	end

	assign stat.is_write = !item_q.func;

	// register file storage, valid bits and registered read ports
	logic [63:0]       rf_mem [NREGS];
	logic [NREGS-1:0]  rf_vld_q;
	logic [63:0]       rd_a_q, rd_b_q;
	logic              wr_en;
	logic [RIDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [63:0]       wr_data;

	// decoded fields
	logic [7:0]  b0, opc, modrm, sib, rex;
	logic        rex_pres, is_mem, has_sib, disp8, disp32, rip_rel, no_base, no_index;
	logic [1:0]  md;
	logic [2:0]  regf, rm, mpos, dpos;
	logic [3:0]  len;
	logic [1:0]  st;
	logic [63:0] disp, shifted, base_term, index_term, t0, t1, ea, divisor;
	logic [3:0]  idx_full;

	// byte decode
	always_comb begin
		b0       = byte_at(item_q.insn_bytes, 3'd0);
		rex_pres = (b0[7:4] == REX_HI);
		rex      = rex_pres ? b0 : 8'h00;
		opc      = byte_at(item_q.insn_bytes, rex_pres ? 3'd1 : 3'd0);
		modrm    = byte_at(item_q.insn_bytes, rex_pres ? 3'd2 : 3'd1);
		md       = modrm[7:6];
		regf     = modrm[5:3];
		rm       = modrm[2:0];
		mpos     = rex_pres ? 3'd3 : 3'd2;
		is_mem   = (md != 2'd3);
		has_sib  = is_mem && (rm == 3'd4);
		sib      = has_sib ? byte_at(item_q.insn_bytes, mpos) : 8'h00;
		dpos     = mpos + {2'b00, has_sib};
		disp8    = is_mem && (md == 2'd1);
		disp32   = is_mem && ((md == 2'd2) ||
			((md == 2'd0) && ((rm == 3'd5) || ((rm == 3'd4) && (sib[2:0] == 3'd5)))));
		shifted  = item_q.insn_bytes >> {dpos, 3'b000};
		if (disp8)
			disp = {{56{shifted[7]}}, shifted[7:0]};
		else if (disp32)
			disp = {{32{shifted[31]}}, shifted[31:0]};
		else
			disp = '0;
		len = {1'b0, dpos} + (disp8 ? 4'd1 : (disp32 ? 4'd4 : 4'd0));
		// error priority: prefix, opcode, reg field
		if ((b0 == PFX_OPSIZE) || (b0 == PFX_ADSIZE))
			st = ST_PREFIX;
		else if (opc != OPC_DIV)
			st = ST_OPCODE;
		else if (regf[2:1] != 2'b11)
			st = ST_REGFLD;
		else
			st = ST_OK;
	end

	// register addresses for base or rm and for index
	assign rd_addr_a = cmd.addr ? RAX_IDX : {rex[0], (has_sib ? sib[2:0] : rm)};
	assign rd_addr_b = {rex[1], sib[5:3]};
	assign idx_full  = rd_addr_b;

	// effective address: one three-term add
	always_comb begin
		rip_rel    = (md == 2'd0) && (rm == 3'd5);
		no_index   = (idx_full == 4'd4);
		no_base    = (md == 2'd0) && (sib[2:0] == 3'd5);
		index_term = (has_sib && !no_index) ? (rd_b_q << sib[7:6]) : 64'd0;
		base_term  = (has_sib && no_base) ? 64'd0 : rd_a_q;
		t0 = rip_rel ? item_q.fault_rip : base_term;
		t1 = rip_rel ? {60'd0, len} : index_term;
		ea = is_mem ? (t0 + t1 + disp) : 64'd0;
		divisor = is_mem ? item_q.mem_operand : rd_a_q;
		if (!rex[3]) divisor = {{32{divisor[31]}}, divisor[31:0]};
	end

	// address step results
	logic        ok_q, w_q, div_m1_q, uses_mem_q;
	logic [1:0]  st_q;
	logic [3:0]  len_q;
	logic [63:0] ea_q, next_rip_q, rdx_q;

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			ok_q       <= (st == ST_OK);
			st_q       <= st;
			w_q        <= rex[3];
			div_m1_q   <= regf[0] && (divisor == {64{1'b1}});
			uses_mem_q <= (st == ST_OK) && is_mem;
			len_q      <= (st == ST_OK) ? len : 4'd0;
			ea_q       <= (st == ST_OK) ? ea : 64'd0;
			next_rip_q <= item_q.fault_rip + ((st == ST_OK) ? {60'd0, len} : 64'd0);
		end
	end

	// fixup of rax and rdx
	logic [63:0] dividend, fix_rax, fix_rdx;

	always_comb begin
		dividend = w_q ? rd_a_q : {32'd0, rd_a_q[31:0]};
		fix_rax  = (ok_q && div_m1_q) ? dividend : 64'd0;
		fix_rdx  = (ok_q && !div_m1_q) ? dividend : 64'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fix) rdx_q <= fix_rdx;
	end

	// write port select
	always_comb begin
		wr_en   = cmd.wr_item || ((cmd.fix || cmd.wr_rdx) && ok_q);
		wr_addr = cmd.wr_item ? item_q.reg_index : (cmd.fix ? RAX_IDX : RDX_IDX);
		wr_data = cmd.wr_item ? item_q.reg_value : (cmd.fix ? fix_rax : rdx_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) rf_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wr_en) begin
			rf_vld_q[wr_addr] <= 1'b1;
		end
	end

	// registered reads, never-written entries read as zero
	always_ff @(posedge clk) begin
		if (cmd.rd_ops || cmd.addr)
			rd_a_q <= rf_vld_q[rd_addr_a] ? rf_mem[rd_addr_a] : 64'd0;
		if (cmd.rd_ops)
			rd_b_q <= rf_vld_q[rd_addr_b] ? rf_mem[rd_addr_b] : 64'd0;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.wr_item) begin
			result <= '0;
		end else if (cmd.fix) begin
			result.new_rax     <= fix_rax;
			result.new_rdx     <= fix_rdx;
			result.next_rip    <= next_rip_q;
			result.insn_length <= len_q;
			result.eff_addr    <= ea_q;
			result.uses_memory <= uses_mem_q;
			result.status      <= st_q;
		end
	end

endmodule

[rtl/divide_fault_decode_and_fixup.sv]
// divide_fault_decode_and_fixup: top level joining controller and datapath
// sequence: a write item's result is loaded in the read state, a fault item's in the fix state
// after the read and address states; a new item is taken only back in idle, as set by the
// single write port and two read ports of the register file that the sequencer steps through
// reset: arst_n clears the state machine and marks all sixteen registers as zero
// done marks each result for one cycle; the receiver cannot stall
`timescale 1ns / 1ps

module divide_fault_decode_and_fixup import dfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer
	dfd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath
	dfd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

endmodule
